[src/hold_modify_color_line_decoder_assert.svh]
// Assertion macros for the hold-and-modify line decoder.
// Users must have clk and rst in scope; rst disables the check.
`ifndef HOLD_MODIFY_COLOR_LINE_DECODER_ASSERT_SVH
`define HOLD_MODIFY_COLOR_LINE_DECODER_ASSERT_SVH

// Same-cycle implication
`define HMCL_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hmcl assertion failed");

// Next-cycle implication
`define HMCL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hmcl assertion failed");

`endif

[src/hmcl_pkg.sv]
// Shared types and constants for the hold-and-modify line decoder.
// No dependencies; used by every module of the block.
`default_nettype none
package hmcl_pkg;
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int NUM_BASE      = 8;
  localparam int BASE_SEL_W    = 3;
  localparam int IDX_W         = 8;
  localparam int RGB_W         = 24;
  localparam int CH_W          = 8;
  localparam int OP_W          = 6;
  localparam int CFG_AW        = 5;
  localparam int CFG_DW        = 32;

  // Item command codes
  typedef enum logic [1:0] {
    CMD_PAL_WRITE = 2'd0,
    CMD_START     = 2'd1,
    CMD_DATA      = 2'd2
  } cmd_t;

  // Action field, bits 5:3 of a 6-bit op
  localparam logic [2:0] OP_LOAD  = 3'b000;
  localparam logic [2:0] OP_BLEND = 3'b001;

  // Channel field, bits 5:4 of an add op
  localparam logic [1:0] CH_RED   = 2'b01;
  localparam logic [1:0] CH_GREEN = 2'b10;

  typedef logic [NUM_BASE-1:0][IDX_W-1:0] base_idx_t;

  // One issued output slot, travelling with the registered palette read
  typedef struct packed {
    logic            valid;
    logic            start;  // start-line load, no pixel
    logic            first;  // first copy of a pixel: apply the op
    logic            last;   // final pixel of the item
    logic            zero;   // palette index beyond depth
    logic [OP_W-1:0] op;
  } slot_t;
endpackage
`default_nettype wire

[src/hmcl_cfg.sv]
// APB register file holding the eight base colour palette indexes.
// Depends on hmcl_pkg.
`default_nettype none
module hmcl_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hmcl_pkg::CFG_AW-1:0] paddr,
  input  logic [hmcl_pkg::CFG_DW-1:0] pwdata,
  output logic [hmcl_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output hmcl_pkg::base_idx_t         base_index
);
  import hmcl_pkg::*;

  logic                  wr_en;
  logic [BASE_SEL_W-1:0] reg_sel;

  // Decode word address
  assign reg_sel = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Hold register values
  always_ff @(posedge clk) begin
    if (rst) begin
      base_index <= '0;
    end else if (wr_en) begin
      base_index[reg_sel] <= pwdata[IDX_W-1:0];
    end
  end

  // Read back
  assign prdata = CFG_DW'(base_index[reg_sel]);
endmodule
`default_nettype wire

[src/hmcl_seq.sv]
// Input register, slot sequencer and palette memory of the line decoder.
// Depends on hmcl_pkg and the assertion macro header.
`default_nettype none
`include "hold_modify_color_line_decoder_assert.svh"
module hmcl_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 command,
  input  logic [hmcl_pkg::IDX_W-1:0] palette_slot,
  input  logic [hmcl_pkg::RGB_W-1:0] palette_rgb,
  input  logic [hmcl_pkg::IDX_W-1:0] back_index,
  input  logic                       double_width,
  input  logic [7:0]                 first_byte,
  input  logic [7:0]                 second_byte,
  input  logic [7:0]                 third_byte,
  input  hmcl_pkg::base_idx_t        base_index,
  input  logic                       take,
  output hmcl_pkg::slot_t            slot,
  output logic [hmcl_pkg::RGB_W-1:0] pal_rdata
);
  import hmcl_pkg::*;

  // Held input item
  logic             q_valid;
  logic [1:0]       q_cmd;
  logic [IDX_W-1:0] q_pslot;
  logic [RGB_W-1:0] q_rgb;
  logic [IDX_W-1:0] q_back;
  logic             q_dw;
  logic [7:0]       q_b0;
  logic [7:0]       q_b1;
  logic [7:0]       q_b2;

  logic             doubled;
  logic [2:0]       cnt;
  logic [2:0]       last_cnt;
  logic [1:0]       op_idx;
  logic [OP_W-1:0]  cur_op;
  logic [IDX_W-1:0] rd_idx;
  logic             adv;
  logic             done;
  logic             is_start;
  logic             is_data;
  logic             rd_en;
  logic             wr_en;

  logic [RGB_W-1:0] pal_mem [PALETTE_DEPTH];

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return {1'b0, idx} < (IDX_W + 1)'(PALETTE_DEPTH);
  endfunction

  // Decode held command
  always_comb begin
    is_start = 1'b0;
    is_data  = 1'b0;
    unique case (cmd_t'(q_cmd))
      CMD_START: is_start = 1'b1;
      CMD_DATA:  is_data  = 1'b1;
      default: begin
        is_start = 1'b0;
        is_data  = 1'b0;
      end
    endcase
  end

  // Pick the current op and its slot position
  assign op_idx   = doubled ? cnt[2:1] : cnt[1:0];
  assign last_cnt = doubled ? 3'd7 : 3'd3;
  assign done     = !is_data || (cnt == last_cnt);

  always_comb begin
    unique case (op_idx)
      2'd0:    cur_op = q_b0[7:2];
      2'd1:    cur_op = {q_b0[1:0], q_b1[7:4]};
      2'd2:    cur_op = {q_b1[3:0], q_b2[7:6]};
      default: cur_op = q_b2[5:0];
    endcase
  end

  assign rd_idx   = is_start ? q_back : base_index[cur_op[BASE_SEL_W-1:0]];
  assign adv      = q_valid && (!slot.valid || take);
  assign rd_en    = adv && (is_start || is_data);
  assign wr_en    = adv && (cmd_t'(q_cmd) == CMD_PAL_WRITE) && in_range(q_pslot);
  assign in_ready = !q_valid || (adv && done);

  // Hold the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_cmd   <= command;
      q_pslot <= palette_slot;
      q_rgb   <= palette_rgb;
      q_back  <= back_index;
      q_dw    <= double_width;
      q_b0    <= first_byte;
      q_b1    <= second_byte;
      q_b2    <= third_byte;
    end
  end

  // Advance slot counter and doubled flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      doubled <= 1'b0;
    end else if (adv) begin
      if (is_start) begin
        doubled <= q_dw;
      end
      if (is_data) begin
        cnt <= done ? 3'd0 : cnt + 3'd1;
      end
    end
  end

  // Issue one slot per cycle unless the held slot is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (adv) begin
      slot.valid <= is_start || is_data;
      slot.start <= is_start;
      slot.first <= !(doubled && cnt[0]);
      slot.last  <= is_data && done;
      slot.zero  <= !in_range(rd_idx);
      slot.op    <= cur_op;
    end else if (take) begin
      slot.valid <= 1'b0;
    end
  end

  // Palette memory: write from the held item, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal_mem[q_pslot[PAL_AW-1:0]] <= q_rgb;
    end
    if (rd_en) begin
      pal_rdata <= pal_mem[rd_idx[PAL_AW-1:0]];
    end
  end

  `HMCL_ASSERT_NEXT(a_slot_hold, slot.valid && !take, slot.valid && $stable(slot) && $stable(pal_rdata))
  `HMCL_ASSERT_IMP(a_cnt_single, !doubled, cnt[2] == 1'b0)
  `HMCL_ASSERT_IMP(a_start_not_last, slot.valid && slot.start, !slot.last)
endmodule
`default_nettype wire

[src/hmcl_exec.sv]
// Colour update stage and output register of the line decoder.
// Depends on hmcl_pkg and the assertion macro header.
`default_nettype none
`include "hold_modify_color_line_decoder_assert.svh"
module hmcl_exec (
  input  logic                       clk,
  input  logic                       rst,
  input  hmcl_pkg::slot_t            slot,
  input  logic [hmcl_pkg::RGB_W-1:0] pal_rdata,
  output logic                       take,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hmcl_pkg::RGB_W-1:0] pixel_rgb,
  output logic                       last_pixel
);
  import hmcl_pkg::*;

  logic [RGB_W-1:0] running;
  logic [RGB_W-1:0] pal;
  logic [RGB_W-1:0] new_color;

  function automatic logic [RGB_W-1:0] apply_op(input logic [OP_W-1:0] op,
                                                input logic [RGB_W-1:0] cur,
                                                input logic [RGB_W-1:0] base);
    logic [CH_W-1:0]  step;
    logic [CH_W:0]    sum;
    logic [RGB_W-1:0] res;
    step = {op[3], op[3:0], 3'b000};
    res  = cur;
    sum  = '0;
    unique case (op[5:3])
      OP_LOAD: res = base;
      OP_BLEND: begin
        for (int c = 0; c < 3; c++) begin
          sum = {1'b0, cur[c*CH_W +: CH_W]} + {1'b0, base[c*CH_W +: CH_W]};
          res[c*CH_W +: CH_W] = sum[CH_W:1];
        end
      end
      default: begin
        // Wrapping add to the selected channel
        case (op[5:4])
          CH_RED:   res[CH_W-1:0]        = cur[CH_W-1:0] + step;
          CH_GREEN: res[2*CH_W-1:CH_W]   = cur[2*CH_W-1:CH_W] + step;
          default:  res[3*CH_W-1:2*CH_W] = cur[3*CH_W-1:2*CH_W] + step;
        endcase
      end
    endcase
    return res;
  endfunction

  // Indexes beyond the palette read as black
  assign pal       = slot.zero ? '0 : pal_rdata;
  assign new_color = apply_op(slot.op, running, pal);
  assign take      = slot.valid && (!out_valid || out_ready);

  // Update running colour and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take && slot.start) begin
        running <= pal;
      end else if (take && slot.first) begin
        running <= new_color;
      end
      if (take && !slot.start) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load output pixel
  always_ff @(posedge clk) begin
    if (take && !slot.start) begin
      pixel_rgb  <= slot.first ? new_color : running;
      last_pixel <= slot.last;
    end
  end

  `HMCL_ASSERT_NEXT(a_data_shows, take && !slot.start, out_valid)
  `HMCL_ASSERT_NEXT(a_repeat_holds, take && !slot.start && !slot.first, pixel_rgb == $past(running))
  `HMCL_ASSERT_NEXT(a_start_loads, take && slot.start, running == $past(pal))
endmodule
`default_nettype wire

[src/hold_modify_color_line_decoder.sv]
// Hold-and-modify color line decoder. A palette-write item and an unused
// command give no pixel; a start-line item reads the background color from
// the palette. A data item yields four pixels, or eight when doubled. The
// sequencer issues one palette read and one pixel per cycle while the output
// does not stall, a pace set by the single read port of the palette memory
// and the one-pixel output register. The next item is taken while the
// previous one drains, so items flow back to back. The first pixel passes
// the input register, the slot register with its palette read, and the
// output register. Palette entries read before being written return
// unknown color.
// Depends on hmcl_pkg, hmcl_cfg, hmcl_seq and hmcl_exec.
`default_nettype none
module hold_modify_color_line_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hmcl_pkg::CFG_AW-1:0] paddr,
  input  logic [hmcl_pkg::CFG_DW-1:0] pwdata,
  output logic [hmcl_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [hmcl_pkg::IDX_W-1:0]  palette_slot,
  input  logic [hmcl_pkg::RGB_W-1:0]  palette_rgb,
  input  logic [hmcl_pkg::IDX_W-1:0]  back_index,
  input  logic                        double_width,
  input  logic [7:0]                  first_byte,
  input  logic [7:0]                  second_byte,
  input  logic [7:0]                  third_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hmcl_pkg::RGB_W-1:0]  pixel_rgb,
  output logic                        last_pixel
);
  import hmcl_pkg::*;

  base_idx_t        base_index;
  slot_t            slot;
  logic [RGB_W-1:0] pal_rdata;
  logic             take;

  hmcl_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .base_index (base_index)
  );

  hmcl_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .palette_slot (palette_slot),
    .palette_rgb  (palette_rgb),
    .back_index   (back_index),
    .double_width (double_width),
    .first_byte   (first_byte),
    .second_byte  (second_byte),
    .third_byte   (third_byte),
    .base_index   (base_index),
    .take         (take),
    .slot         (slot),
    .pal_rdata    (pal_rdata)
  );

  hmcl_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .slot       (slot),
    .pal_rdata  (pal_rdata),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_rgb  (pixel_rgb),
    .last_pixel (last_pixel)
  );
endmodule
`default_nettype wire
